// ===== design/plcr_pkg.sv =====
// Package for the packet length code receiver: status codes, field widths
// and the CRC-8 column table. No dependencies.
`timescale 1ns / 1ps

package plcr_pkg;

    localparam int unsigned LEN_W     = 16;
    localparam int unsigned CODE_W    = 32;
    localparam int unsigned CRC_W     = 8;
    localparam int unsigned CNT_W     = 32;
    localparam int unsigned NIB_W     = 4;
    localparam int unsigned SHIFT_W   = 40;
    localparam int unsigned CFG_IDX_W = 8;

    localparam logic [NIB_W-1:0]     NIBBLES_PER_CODE = 4'd10;
    localparam logic [LEN_W-1:0]     SIGNAL_RESET     = 16'd61;
    localparam logic [LEN_W-1:0]     BASE_RESET       = 16'd392;
    localparam logic [CFG_IDX_W-1:0] REG_SIGNAL_LEN   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_LEN     = 8'd1;

    // Per-item outcome reported on the result beat
    typedef enum logic [2:0] {
        ST_IGNORED   = 3'd0,
        ST_STARTED   = 3'd1,
        ST_NIBBLE    = 3'd2,
        ST_BAD_LEN   = 3'd3,
        ST_RANGE     = 3'd4,
        ST_PASS      = 3'd5,
        ST_FAIL      = 3'd6
    } t_status;

    // CRC-8 (poly 0x07, init 0) is linear in the data bits: entry i is the
    // register contribution of data bit i, i.e. x^i mod the polynomial.
    typedef logic [CRC_W-1:0] t_crc_tab [CODE_W];
    localparam t_crc_tab CRC_COL = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
        8'h07, 8'h0E, 8'h1C, 8'h38, 8'h70, 8'hE0, 8'hC7, 8'h89,
        8'h15, 8'h2A, 8'h54, 8'hA8, 8'h57, 8'hAE, 8'h5B, 8'hB6,
        8'h6B, 8'hD6, 8'hAB, 8'h51, 8'hA2, 8'h43, 8'h86, 8'h0B
    };

    // XOR of the table columns selected by the word's bits
    function automatic logic [CRC_W-1:0] crc8_word(input logic [CODE_W-1:0] word);
        logic [CRC_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < CODE_W; i++) begin
            if (word[i]) begin
                acc = acc ^ CRC_COL[i];
            end
        end
        return acc;
    endfunction

endpackage

// ===== design/packet_length_code_receiver_top.sv =====
// Packet length code receiver: decodes nibbles from packet lengths, checks
// the CRC-8 of each 32-bit code and keeps pass/fail counters.
// Depends on plcr_pkg.
`timescale 1ns / 1ps

// Path: input register, then decode/CRC logic into the result register.
// Throughput: one beat per cycle unless the result stream stalls; the
//   decode state is updated as each item leaves the input register, so
//   back-to-back items see it at once.
// Reset: synchronous, active low; idle, counters zero, signal_length 61,
//   base_length 392.
module packet_length_code_receiver_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input stream: tdata = packet_length[15:0]
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [plcr_pkg::LEN_W-1:0]         i_s_tdata,
    // result stream
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // tdata = short_code[31:0], received_crc[39:32], computed_crc[47:40],
    //         codes_total[79:48], codes_passed[111:80], codes_failed[143:112]
    output logic [143:0]                       o_m_tdata,
    // tuser = status[2:0]
    output logic [2:0]                         o_m_tuser,
    // configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [plcr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [plcr_pkg::LEN_W-1:0]         i_cfg_data
);

    // Configuration registers
    logic [plcr_pkg::LEN_W-1:0]   r_signal_len;
    logic [plcr_pkg::LEN_W-1:0]   r_base_len;

    // Input register
    logic                         r_in_valid;
    logic [plcr_pkg::LEN_W-1:0]   r_len;

    // Decode state
    logic                         r_decoding,  n_decoding;
    logic [plcr_pkg::NIB_W-1:0]   r_nib_cnt,   n_nib_cnt;
    logic [plcr_pkg::SHIFT_W-1:0] r_shift,     n_shift;
    logic [plcr_pkg::CNT_W-1:0]   r_total,     n_total;
    logic [plcr_pkg::CNT_W-1:0]   r_pass,      n_pass;
    logic [plcr_pkg::CNT_W-1:0]   r_fail,      n_fail;

    // Result register
    logic                         r_out_valid;
    plcr_pkg::t_status            r_status,    n_status;
    logic [plcr_pkg::CODE_W-1:0]  r_code,      n_code;
    logic [plcr_pkg::CRC_W-1:0]   r_rx_crc,    n_rx_crc;
    logic [plcr_pkg::CRC_W-1:0]   r_calc_crc,  n_calc_crc;

    // Datapath intermediates
    logic                         advance;
    logic [plcr_pkg::LEN_W-1:0]   diff;
    logic [plcr_pkg::SHIFT_W-1:0] shifted;
    logic [plcr_pkg::NIB_W-1:0]   cnt_inc;
    logic [plcr_pkg::CRC_W-1:0]   crc_calc;

    // Handshakes: result register frees when empty or taken
    assign advance     = !r_out_valid || i_m_tready;
    assign o_s_tready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    // Config writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signal_len <= plcr_pkg::SIGNAL_RESET;
            r_base_len   <= plcr_pkg::BASE_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == plcr_pkg::REG_SIGNAL_LEN) begin
                r_signal_len <= i_cfg_data;
            end else if (i_cfg_index == plcr_pkg::REG_BASE_LEN) begin
                r_base_len <= i_cfg_data;
            end
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_len <= i_s_tdata;
        end
    end

    // Nibble decode, CRC and counter update
    assign diff     = r_len - r_base_len;
    assign shifted  = {r_shift[plcr_pkg::SHIFT_W-plcr_pkg::NIB_W-1:0],
                       diff[plcr_pkg::NIB_W+3:4]};
    assign cnt_inc  = r_nib_cnt + 4'd1;
    assign crc_calc = plcr_pkg::crc8_word(shifted[plcr_pkg::SHIFT_W-1:plcr_pkg::CRC_W]);

    always_comb begin
        n_decoding = r_decoding;
        n_nib_cnt  = r_nib_cnt;
        n_shift    = r_shift;
        n_total    = r_total;
        n_pass     = r_pass;
        n_fail     = r_fail;
        n_status   = plcr_pkg::ST_IGNORED;
        n_code     = '0;
        n_rx_crc   = '0;
        n_calc_crc = '0;
        priority if (!r_decoding) begin
            if (r_len == r_signal_len) begin
                n_decoding = 1'b1;
                n_nib_cnt  = '0;
                n_shift    = '0;
                n_status   = plcr_pkg::ST_STARTED;
            end
        end else if (r_len < r_base_len || diff[3:0] != 4'd0) begin
            n_decoding = 1'b0;
            n_nib_cnt  = '0;
            n_shift    = '0;
            n_status   = plcr_pkg::ST_BAD_LEN;
        end else if (diff[plcr_pkg::LEN_W-1:8] != '0) begin
            // quotient above 15
            n_decoding = 1'b0;
            n_nib_cnt  = '0;
            n_shift    = '0;
            n_status   = plcr_pkg::ST_RANGE;
        end else if (cnt_inc == plcr_pkg::NIBBLES_PER_CODE) begin
            // last nibble: code and CRC complete
            n_decoding = 1'b0;
            n_nib_cnt  = '0;
            n_shift    = '0;
            n_code     = shifted[plcr_pkg::SHIFT_W-1:plcr_pkg::CRC_W];
            n_rx_crc   = shifted[plcr_pkg::CRC_W-1:0];
            n_calc_crc = crc_calc;
            n_total    = r_total + 32'd1;
            if (crc_calc == shifted[plcr_pkg::CRC_W-1:0]) begin
                n_pass   = r_pass + 32'd1;
                n_status = plcr_pkg::ST_PASS;
            end else begin
                n_fail   = r_fail + 32'd1;
                n_status = plcr_pkg::ST_FAIL;
            end
        end else begin
            n_nib_cnt = cnt_inc;
            n_shift   = shifted;
            n_status  = plcr_pkg::ST_NIBBLE;
        end
    end

    // State and result registers advance together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decoding  <= 1'b0;
            r_nib_cnt   <= '0;
            r_shift     <= '0;
            r_total     <= '0;
            r_pass      <= '0;
            r_fail      <= '0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_decoding <= n_decoding;
                r_nib_cnt  <= n_nib_cnt;
                r_shift    <= n_shift;
                r_total    <= n_total;
                r_pass     <= n_pass;
                r_fail     <= n_fail;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_status   <= n_status;
            r_code     <= n_code;
            r_rx_crc   <= n_rx_crc;
            r_calc_crc <= n_calc_crc;
        end
    end

    // Output beat; counters in the result register are the post-item values
    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_status;
    assign o_m_tdata  = {r_fail, r_pass, r_total, r_calc_crc, r_rx_crc, r_code};

    // Checks
    a_nib_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nib_cnt < plcr_pkg::NIBBLES_PER_CODE)
        else $error("nibble count past code length");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_decoding |-> (r_nib_cnt == '0 && r_shift == '0))
        else $error("idle with leftover nibble state");

    a_counters_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total == r_pass + r_fail)
        else $error("total differs from pass plus fail");

    a_pass_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == plcr_pkg::ST_PASS) |-> (r_rx_crc == r_calc_crc))
        else $error("pass reported with mismatching CRC");

    a_code_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != plcr_pkg::ST_PASS && r_status != plcr_pkg::ST_FAIL)
        |-> (r_code == '0 && r_rx_crc == '0 && r_calc_crc == '0))
        else $error("code fields set without completion");

endmodule

// ===== dv/packet_length_code_receiver_top_tb.sv =====
// Testbench for packet_length_code_receiver_top: drives length beats and
// checks every result beat against a cycle-free model of the decoder.
// Depends on plcr_pkg and the design under test.
`timescale 1ns / 1ps

module packet_length_code_receiver_top_tb;
    import plcr_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 155;
    localparam int NUM_PHASES   = 10;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_NIBBLE   = 15;

    // Decoder model plus the queue of result beats it predicts
    class code_tracker;
        localparam logic [CRC_W-1:0] CRC8_POLY = 8'h07;

        typedef struct {
            t_status           status;
            logic [CODE_W-1:0] code;
            logic [CRC_W-1:0]  rx_crc;
            logic [CRC_W-1:0]  calc_crc;
            logic [CNT_W-1:0]  total;
            logic [CNT_W-1:0]  passed;
            logic [CNT_W-1:0]  failed;
        } t_code_result;

        logic [LEN_W-1:0]   signal_len;
        logic [LEN_W-1:0]   base_len;
        bit                 decoding;
        logic [NIB_W-1:0]   nib_cnt;
        logic [SHIFT_W-1:0] nib_shift;
        logic [CNT_W-1:0]   total_cnt;
        logic [CNT_W-1:0]   pass_cnt;
        logic [CNT_W-1:0]   fail_cnt;
        t_code_result       pending_results[$];
        int                 errors;
        int                 beats_seen;

        function new();
            signal_len = SIGNAL_RESET;
            base_len   = BASE_RESET;
            go_idle();
            total_cnt  = '0;
            pass_cnt   = '0;
            fail_cnt   = '0;
            errors     = 0;
            beats_seen = 0;
        endfunction

        function void go_idle();
            decoding  = 1'b0;
            nib_cnt   = '0;
            nib_shift = '0;
        endfunction

        // Unknown indexes are dropped by the block
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] val);
            if (idx == REG_SIGNAL_LEN) begin
                signal_len = val;
            end else if (idx == REG_BASE_LEN) begin
                base_len = val;
            end
        endfunction

        // Bit-serial CRC-8, MSB first, no augmentation
        function logic [CRC_W-1:0] crc8_calc(logic [CODE_W-1:0] word);
            logic [CRC_W-1:0] crc;
            logic             top;
            crc = '0;
            for (int i = CODE_W - 1; i >= 0; i--) begin
                top = crc[7];
                crc = {crc[6:0], word[i]};
                if (top) begin
                    crc = crc ^ CRC8_POLY;
                end
            end
            return crc;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // One accepted length beat -> one predicted result beat
        function void decode_length(logic [LEN_W-1:0] len);
            t_code_result     r;
            logic [LEN_W-1:0] diff;
            r.status   = ST_IGNORED;
            r.code     = '0;
            r.rx_crc   = '0;
            r.calc_crc = '0;
            diff = len - base_len;
            if (!decoding) begin
                if (len == signal_len) begin
                    decoding  = 1'b1;
                    nib_cnt   = '0;
                    nib_shift = '0;
                    r.status  = ST_STARTED;
                end
            end else if (len < base_len || diff[3:0] != 4'd0) begin
                go_idle();
                r.status = ST_BAD_LEN;
            end else if (diff[LEN_W-1:4] > MAX_NIBBLE) begin
                // full quotient, not just its low byte
                go_idle();
                r.status = ST_RANGE;
            end else begin
                nib_shift = {nib_shift[SHIFT_W-5:0], diff[7:4]};
                nib_cnt   = nib_cnt + 4'd1;
                r.status  = ST_NIBBLE;
                if (nib_cnt == NIBBLES_PER_CODE) begin
                    r.code     = nib_shift[SHIFT_W-1:8];
                    r.rx_crc   = nib_shift[7:0];
                    r.calc_crc = crc8_calc(r.code);
                    total_cnt  = total_cnt + 32'd1;
                    if (r.calc_crc == r.rx_crc) begin
                        pass_cnt = pass_cnt + 32'd1;
                        r.status = ST_PASS;
                    end else begin
                        fail_cnt = fail_cnt + 32'd1;
                        r.status = ST_FAIL;
                    end
                    go_idle();
                end
            end
            r.total  = total_cnt;
            r.passed = pass_cnt;
            r.failed = fail_cnt;
            pending_results = {pending_results, r};
        endfunction

        task report(string field, logic [CNT_W-1:0] got, logic [CNT_W-1:0] want);
            errors++;
            $display("%0t: result beat %0d, %s: got %h, want %h",
                     $time, beats_seen, field, got, want);
        endtask

        task check_result(logic [2:0] status, logic [143:0] data);
            t_code_result e;
            beats_seen++;
            if (pending_results.size() == 0) begin
                report("unexpected beat, status", status, '0);
                return;
            end
            e = pending_results.pop_front();
            if (status != e.status)            report("status", status, e.status);
            if (data[31:0] != e.code)          report("short_code", data[31:0], e.code);
            if (data[39:32] != e.rx_crc)       report("received_crc", data[39:32], e.rx_crc);
            if (data[47:40] != e.calc_crc)     report("computed_crc", data[47:40], e.calc_crc);
            if (data[79:48] != e.total)        report("codes_total", data[79:48], e.total);
            if (data[111:80] != e.passed)      report("codes_passed", data[111:80], e.passed);
            if (data[143:112] != e.failed)     report("codes_failed", data[143:112], e.failed);
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [LEN_W-1:0]     i_s_tdata;
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [143:0]         o_m_tdata;
    logic [2:0]           o_m_tuser;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [LEN_W-1:0]     i_cfg_data;

    code_tracker tracker;
    int          burst_left;
    int          seq_items;
    int          cycle_count;
    bit          hold_req;
    bit          started;

    packet_length_code_receiver_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("packet_length_code_receiver_top_tb: done, errors");
        $finish;
    end

    // Both handshakes handled in one process so edge ordering cannot matter
    always @(posedge i_clk) begin
        if (i_rst_n && started) begin
            if (i_s_tvalid && o_s_tready) begin
                tracker.decode_length(i_s_tdata);
            end
            if (o_m_tvalid && i_m_tready) begin
                tracker.check_result(o_m_tuser, o_m_tdata);
            end
        end
    end

    // Result side back-pressure: modes change every so often, plus one long hold
    initial begin
        int mode;
        int left;
        i_m_tready = 1'b0;
        mode = 0;
        left = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_m_tready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(30, 200);
                end
                left--;
                case (mode)
                    0: i_m_tready = 1'b1;
                    1: i_m_tready = $urandom_range(0, 1);
                    2: i_m_tready = ($urandom_range(0, 3) == 0);
                    default: i_m_tready = ~i_m_tready;
                endcase
            end
        end
    end

    // One length beat; the sender runs in bursts with gaps between them
    task send_length(input logic [LEN_W-1:0] len);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            gap = $urandom_range(1, 10);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                                      : $urandom_range(1, 12);
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        burst_left--;
        i_s_tvalid = 1'b1;
        i_s_tdata  = len;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // Stop sending and wait until every predicted beat has come back
    task drain();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        burst_left = 0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function logic [LEN_W-1:0] nibble_len(logic [NIB_W-1:0] nib);
        return tracker.base_len + {nib, 4'b0};
    endfunction

    // Signal length, eight code nibbles (MSB first), then the two CRC nibbles
    task send_code(input logic [CODE_W-1:0] code, input logic [CRC_W-1:0] crc);
        logic [SHIFT_W-1:0] word;
        word = {code, crc};
        send_length(tracker.signal_len);
        for (int i = 9; i >= 0; i--) begin
            send_length(nibble_len(word[i*4 +: 4]));
        end
        seq_items += 11;
    endtask

    // Start a code, take some good nibbles, then break it
    task send_broken();
        int               good;
        int               kind;
        logic [LEN_W-1:0] bad;
        good = $urandom_range(0, 9);
        kind = $urandom_range(0, 5);
        send_length(tracker.signal_len);
        for (int i = 0; i < good; i++) begin
            send_length(nibble_len($urandom_range(0, MAX_NIBBLE)));
        end
        case (kind)
            0: begin
                if (tracker.base_len != 0) bad = $urandom_range(0, tracker.base_len - 1);
                else bad = nibble_len($urandom_range(0, MAX_NIBBLE)) + 1'b1;
            end
            1: bad = nibble_len($urandom_range(0, MAX_NIBBLE)) + $urandom_range(1, 15);
            2: bad = tracker.base_len + 16 * $urandom_range(16, 4095);
            // quotient whose low byte alone would look legal
            3: bad = tracker.base_len + 16 * (256 * $urandom_range(1, 15)
                                              + $urandom_range(0, MAX_NIBBLE));
            4: bad = tracker.signal_len;
            default: bad = $urandom_range(0, 16'hFFFF);
        endcase
        send_length(bad);
        seq_items += good + 2;
    endtask

    task send_noise();
        int n;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 7) == 0) send_length(tracker.signal_len);
            else send_length($urandom_range(0, 16'hFFFF));
        end
        seq_items += n;
    endtask

    task random_traffic(input int budget);
        int               pick;
        logic [CODE_W-1:0] code;
        logic [CRC_W-1:0]  crc;
        seq_items = 0;
        while (seq_items < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                case ($urandom_range(0, 9))
                    0: code = '0;
                    1: code = '1;
                    default: code = $urandom;
                endcase
                crc = ($urandom_range(0, 9) < 7) ? tracker.crc8_calc(code)
                                                 : $urandom_range(0, 255);
                send_code(code, crc);
            end else if (pick < 82) begin
                send_broken();
            end else begin
                send_noise();
            end
        end
    endtask

    // Reset, directed checks, then configuration phases of random traffic
    initial begin
        logic [LEN_W-1:0] sig;
        logic [LEN_W-1:0] base;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        hold_req    = 1'b0;
        started     = 1'b0;
        burst_left  = 0;
        tracker     = new();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        started = 1'b1;

        // Directed part, reset configuration
        send_length('0);
        send_length('1);
        send_code('1, tracker.crc8_calc('1));
        send_length(SIGNAL_RESET);
        send_length(BASE_RESET - 1'b1);
        send_length(SIGNAL_RESET);
        send_length(BASE_RESET + 1'b1);
        send_length(SIGNAL_RESET);
        send_length(BASE_RESET + 16'd256);
        send_length(SIGNAL_RESET);
        send_length(BASE_RESET + 16'd4096);
        send_length(SIGNAL_RESET);
        send_length(SIGNAL_RESET);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin sig = SIGNAL_RESET; base = BASE_RESET; end
                1: begin sig = '0;          base = '0; end
                2: begin sig = '1;          base = 16'hFFFF - 16 * MAX_NIBBLE; end
                3: begin sig = '0;          base = '1; end
                4: begin sig = '1;          base = '0; end
                default: begin
                    sig  = $urandom_range(0, 16'hFFFF);
                    base = $urandom_range(0, 16'hFFFF - 16 * MAX_NIBBLE);
                end
            endcase
            write_reg($urandom_range(REG_BASE_LEN + 1, 255), $urandom_range(0, 16'hFFFF));
            write_reg(REG_SIGNAL_LEN, sig);
            write_reg(REG_BASE_LEN, base);
            if (p == 3) begin
                // all-zero code has a zero CRC, the one pass this base allows
                send_code('0, '0);
            end
            if (p == 2) begin
                hold_req = 1'b1;
            end
            random_traffic(PHASE_ITEMS);
            drain();
        end

        if (tracker.errors == 0) begin
            $display("packet_length_code_receiver_top_tb: done, clean");
        end else begin
            $display("packet_length_code_receiver_top_tb: done, errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/plcr_pkg.sv
design/packet_length_code_receiver_top.sv
dv/packet_length_code_receiver_top_tb.sv
